// File: design/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types and constants of the selective-repeat sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

  localparam int unsigned MaxWindowDef = 32;
  localparam int unsigned SeqW         = 16;
  localparam int unsigned CntW         = 17;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 16;
  localparam int unsigned WsizeW       = 6;
  localparam int unsigned KindW        = 3;
  localparam int unsigned OpW          = 2;

  localparam logic [WsizeW-1:0] WindowSizeRst  = 6'd5;
  localparam logic [SeqW-1:0]   PacketCountRst = 16'd1;
  localparam logic [SeqW-1:0]   TimeoutRst     = 16'd500;

  typedef enum logic [OpW-1:0] {
    OP_SEND    = 2'd0,
    OP_ACK     = 2'd1,
    OP_TICK    = 2'd2,
    OP_RESTART = 2'd3
  } op_e;

  typedef enum logic [KindW-1:0] {
    K_SEND      = 3'd0,
    K_RESEND    = 3'd1,
    K_FULL      = 3'd2,
    K_ACK       = 3'd3,
    K_IGNORED   = 3'd4,
    K_DONE      = 3'd5,
    K_NOTIMEOUT = 3'd6
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW_SIZE   = 2'd0,
    CFG_PACKET_COUNT  = 2'd1,
    CFG_TIMEOUT_TICKS = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIV_NEXT = 2'd0,
    DIV_ACK  = 2'd1,
    DIV_BASE = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic     capture;
    logic     restart;
    logic     set_done;
    logic     emit;
    kind_e    kind;
    logic     rem_start;
    div_sel_e rem_sel;
    logic     send_commit;
    logic     ack_clear;
    logic     advance;
    logic     base_step;
    logic     scan_read;
    logic     scan_upd;
    logic     flush;
  } srsw_cmd_t;

  typedef struct packed {
    op_e  op;
    logic is_done;
    logic cond_send;
    logic cond_ack;
    logic ack_base1;
    logic rem_done;
    logic pend_cur;
    logic slide_end;
    logic scan_last;
    logic base_gt_pc;
  } srsw_sts_t;

endpackage

// File: design/srsw_rem.sv
// ----------------------------------------------------------------------------
// srsw_rem
// Bit-serial remainder unit: one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module srsw_rem #(
  parameter int unsigned DivW = 6,
  parameter int unsigned DvdW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] rem_o
);

  localparam int unsigned CntBits = $clog2(DvdW + 1);

  logic               busy_q;
  logic [CntBits-1:0] cnt_q;
  logic [DvdW-1:0]    dvd_q;
  logic [DivW-1:0]    rem_q;
  logic [DivW:0]      trial;
  logic [DivW:0]      dvs;
  logic [DivW-1:0]    rem_nx;

  always_comb begin
    trial = {rem_q, dvd_q[DvdW-1]};
    dvs   = {1'b0, divisor_i};
    if (trial >= dvs) begin
      rem_nx = DivW'(trial - dvs);
    end else begin
      rem_nx = trial[DivW-1:0];
    end
  end

  assign done_o = busy_q && (cnt_q == CntBits'(1));
  assign rem_o  = rem_nx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      rem_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntBits'(DvdW);
      dvd_q  <= dividend_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_nx;
      dvd_q  <= {dvd_q[DvdW-2:0], 1'b0};
      cnt_q  <= cnt_q - CntBits'(1);
      if (cnt_q == CntBits'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule

// File: design/srsw_datapath.sv
// ----------------------------------------------------------------------------
// srsw_datapath
// Window counters, config registers, slot store, slot walk and result register.
// ----------------------------------------------------------------------------
module srsw_datapath #(
  parameter int unsigned MaxWindow = srsw_pkg::MaxWindowDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [srsw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [srsw_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [srsw_pkg::OpW-1:0]      operation_i,
  input  logic [srsw_pkg::SeqW-1:0]     ack_number_i,
  input  logic                          ack_good_i,
  input  srsw_pkg::srsw_cmd_t           cmd_i,
  output srsw_pkg::srsw_sts_t           sts_o,
  output logic                          result_valid_o,
  output logic [srsw_pkg::KindW-1:0]    result_kind_o,
  output logic [srsw_pkg::SeqW-1:0]     sequence_res_o,
  output logic                          final_packet_o,
  output logic [srsw_pkg::SeqW-1:0]     window_low_o,
  output logic                          last_of_run_o
);

  import srsw_pkg::*;

  localparam int unsigned SW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int unsigned WW = $clog2(MaxWindow + 1);
  localparam int unsigned XW = CntW + 1;

  // configuration
  logic [WsizeW-1:0] ws_q;
  logic [SeqW-1:0]   pc_q;
  logic [SeqW-1:0]   to_q;
  logic [WW-1:0]     w;

  // captured request
  op_e               op_q;
  logic [SeqW-1:0]   ack_q;
  logic              good_q;

  // window state
  logic [CntW-1:0]      base_q;
  logic [CntW-1:0]      nts_q;
  logic                 done_q;
  logic [MaxWindow-1:0] pend_q;
  logic [SW-1:0]        idx_q;
  logic [WW-1:0]        cnt_q;

  logic [2*SeqW-1:0] mem_q [MaxWindow];
  logic [2*SeqW-1:0] rd_q;

  logic              held_v_q;
  logic [SeqW-1:0]   held_seq_q;

  logic              out_v_q;
  kind_e             out_kind_q;
  logic [SeqW-1:0]   out_seq_q;
  logic              out_final_q;
  logic [SeqW-1:0]   out_wlow_q;
  logic              out_last_q;

  logic              out_v_d;
  kind_e             out_kind_d;
  logic [SeqW-1:0]   out_seq_d;
  logic              out_last_d;

  logic [XW-1:0]     base_x;
  logic [XW-1:0]     nts_x;
  logic [XW-1:0]     ack_x;
  logic [XW-1:0]     w_x;
  logic [CntW-1:0]   nts_m1;
  logic [CntW-1:0]   base_m1;
  logic [SeqW-1:0]   ack_m2;
  logic [SeqW-1:0]   dividend;
  logic              rem_done;
  logic [WW-1:0]     rem_val;
  logic [WW-1:0]     idx_inc;
  logic [WW:0]       cnt_inc;
  logic [SeqW-1:0]   age;
  logic [SeqW-1:0]   age_inc;
  logic [SeqW-1:0]   limit;
  logic              timeout;

  always_comb begin
    if (ws_q == '0) begin
      w = WW'(1);
    end else if (8'(ws_q) > 8'(MaxWindow)) begin
      w = WW'(MaxWindow);
    end else begin
      w = WW'(ws_q);
    end
  end

  always_comb begin
    base_x  = {1'b0, base_q};
    nts_x   = {1'b0, nts_q};
    ack_x   = XW'(ack_q);
    w_x     = XW'(w);
    nts_m1  = nts_q - CntW'(1);
    base_m1 = base_q - CntW'(1);
    ack_m2  = ack_q - SeqW'(2);
    unique case (cmd_i.rem_sel)
      DIV_NEXT: dividend = nts_m1[SeqW-1:0];
      DIV_ACK:  dividend = ack_m2;
      default:  dividend = base_m1[SeqW-1:0];
    endcase
    idx_inc = WW'(idx_q) + WW'(1);
    cnt_inc = (WW + 1)'(cnt_q) + (WW + 1)'(1);
    age     = rd_q[SeqW-1:0];
    age_inc = (age == '1) ? age : age + SeqW'(1);
    limit   = (to_q == '0) ? SeqW'(1) : to_q;
    timeout = age_inc >= limit;
  end

  srsw_rem #(
    .DivW(WW),
    .DvdW(SeqW)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.rem_start),
    .dividend_i (dividend),
    .divisor_i  (w),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  always_comb begin
    sts_o.op         = op_q;
    sts_o.base_gt_pc = base_q > {1'b0, pc_q};
    sts_o.is_done    = done_q || sts_o.base_gt_pc;
    sts_o.cond_send  = (nts_q <= {1'b0, pc_q}) && (nts_x + XW'(1) <= base_x + w_x);
    sts_o.cond_ack   = good_q && (ack_x > base_x) && (ack_x <= base_x + w_x)
                       && (ack_x <= nts_x);
    sts_o.ack_base1  = ack_x == base_x + XW'(1);
    sts_o.rem_done   = rem_done;
    sts_o.pend_cur   = pend_q[idx_q];
    sts_o.scan_last  = cnt_inc == (WW + 1)'(w);
    sts_o.slide_end  = (cnt_inc >= (WW + 1)'(w)) || (base_q + CntW'(1) == nts_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q <= WindowSizeRst;
      pc_q <= PacketCountRst;
      to_q <= TimeoutRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WINDOW_SIZE:   ws_q <= cfg_data_i[WsizeW-1:0];
        CFG_PACKET_COUNT:  pc_q <= cfg_data_i[SeqW-1:0];
        CFG_TIMEOUT_TICKS: to_q <= cfg_data_i[SeqW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_e'(operation_i);
      ack_q  <= ack_number_i;
      good_q <= ack_good_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= CntW'(1);
      nts_q  <= CntW'(1);
      done_q <= 1'b0;
      pend_q <= '0;
      idx_q  <= '0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.restart) begin
        base_q <= CntW'(1);
        nts_q  <= CntW'(1);
        done_q <= 1'b0;
        pend_q <= '0;
      end
      if (cmd_i.set_done) begin
        done_q <= 1'b1;
      end
      if (cmd_i.send_commit) begin
        pend_q[idx_q] <= 1'b1;
        nts_q         <= nts_q + CntW'(1);
      end
      if (cmd_i.ack_clear) begin
        pend_q[idx_q] <= 1'b0;
      end
      if (cmd_i.base_step) begin
        base_q <= base_q + CntW'(1);
      end
      if (cmd_i.rem_start) begin
        cnt_q <= '0;
      end
      if (rem_done) begin
        idx_q <= rem_val[SW-1:0];
      end
      if (cmd_i.advance) begin
        cnt_q <= cnt_q + WW'(1);
        idx_q <= (idx_inc == w) ? '0 : idx_inc[SW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.send_commit) begin
      mem_q[idx_q] <= {nts_q[SeqW-1:0], SeqW'(0)};
    end else if (cmd_i.scan_upd) begin
      mem_q[idx_q] <= {rd_q[2*SeqW-1:SeqW], timeout ? SeqW'(0) : age_inc};
    end
    if (cmd_i.scan_read) begin
      rd_q <= mem_q[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_v_q   <= 1'b0;
      held_seq_q <= '0;
    end else if (cmd_i.rem_start) begin
      held_v_q <= 1'b0;
    end else if (cmd_i.scan_upd && timeout) begin
      held_v_q   <= 1'b1;
      held_seq_q <= rd_q[2*SeqW-1:SeqW];
    end
  end

  always_comb begin
    out_v_d    = 1'b0;
    out_kind_d = cmd_i.kind;
    out_seq_d  = '0;
    out_last_d = 1'b1;
    if (cmd_i.emit) begin
      out_v_d   = 1'b1;
      out_seq_d = (cmd_i.kind == K_SEND) ? nts_q[SeqW-1:0] : '0;
    end
    if (cmd_i.scan_upd && timeout && held_v_q) begin
      out_v_d    = 1'b1;
      out_kind_d = K_RESEND;
      out_seq_d  = held_seq_q;
      out_last_d = 1'b0;
    end
    if (cmd_i.flush) begin
      out_v_d    = 1'b1;
      out_kind_d = held_v_q ? K_RESEND : K_NOTIMEOUT;
      out_seq_d  = held_v_q ? held_seq_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_v_d) begin
      out_kind_q  <= out_kind_d;
      out_seq_q   <= out_seq_d;
      out_final_q <= (out_seq_d != '0) && (out_seq_d == pc_q);
      out_wlow_q  <= base_q[SeqW-1:0];
      out_last_q  <= out_last_d;
    end
  end

  assign result_valid_o = out_v_q;
  assign result_kind_o  = out_kind_q;
  assign sequence_res_o = out_seq_q;
  assign final_packet_o = out_final_q;
  assign window_low_o   = out_wlow_q;
  assign last_of_run_o  = out_last_q;

  a_base_le_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_q <= nts_q)
    else $error("window base passed next sequence");

endmodule

// File: design/srsw_ctrl.sv
// ----------------------------------------------------------------------------
// srsw_ctrl
// Request sequencer: dispatch, slot index wait, slide walk and timeout scan.
// ----------------------------------------------------------------------------
module srsw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  srsw_pkg::srsw_sts_t sts_i,
  output srsw_pkg::srsw_cmd_t cmd_o
);

  import srsw_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b0000000001,
    ST_DISPATCH = 10'b0000000010,
    ST_REM      = 10'b0000000100,
    ST_SEND_WR  = 10'b0000001000,
    ST_ACK_CLR  = 10'b0000010000,
    ST_SLIDE    = 10'b0000100000,
    ST_ACK_FIN  = 10'b0001000000,
    ST_SCAN     = 10'b0010000000,
    ST_UPD      = 10'b0100000000,
    ST_FLUSH    = 10'b1000000000
  } state_e;

  state_e state_q;
  state_e state_d;

  assign busy_o = state_q != ST_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.kind    = K_ACK;
    cmd_o.rem_sel = DIV_BASE;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_d = ST_IDLE;
        if (sts_i.op == OP_RESTART) begin
          cmd_o.restart = 1'b1;
        end else if (sts_i.is_done) begin
          cmd_o.set_done = 1'b1;
          cmd_o.emit     = 1'b1;
          cmd_o.kind     = K_DONE;
        end else begin
          case (sts_i.op)
            OP_SEND: begin
              if (sts_i.cond_send) begin
                cmd_o.rem_start = 1'b1;
                cmd_o.rem_sel   = DIV_NEXT;
                state_d         = ST_REM;
              end else begin
                cmd_o.emit = 1'b1;
                cmd_o.kind = K_FULL;
              end
            end
            OP_ACK: begin
              if (sts_i.cond_ack) begin
                cmd_o.rem_start = 1'b1;
                cmd_o.rem_sel   = DIV_ACK;
                state_d         = ST_REM;
              end else begin
                cmd_o.emit = 1'b1;
                cmd_o.kind = K_IGNORED;
              end
            end
            default: begin
              cmd_o.rem_start = 1'b1;
              cmd_o.rem_sel   = DIV_BASE;
              state_d         = ST_REM;
            end
          endcase
        end
      end
      ST_REM: begin
        if (sts_i.rem_done) begin
          case (sts_i.op)
            OP_SEND: state_d = ST_SEND_WR;
            OP_ACK:  state_d = ST_ACK_CLR;
            default: state_d = ST_SCAN;
          endcase
        end
      end
      ST_SEND_WR: begin
        cmd_o.send_commit = 1'b1;
        cmd_o.emit        = 1'b1;
        cmd_o.kind        = K_SEND;
        state_d           = ST_IDLE;
      end
      ST_ACK_CLR: begin
        cmd_o.ack_clear = 1'b1;
        state_d         = sts_i.ack_base1 ? ST_SLIDE : ST_ACK_FIN;
      end
      ST_SLIDE: begin
        if (sts_i.pend_cur) begin
          state_d = ST_ACK_FIN;
        end else begin
          cmd_o.advance   = 1'b1;
          cmd_o.base_step = 1'b1;
          if (sts_i.slide_end) begin
            state_d = ST_ACK_FIN;
          end
        end
      end
      ST_ACK_FIN: begin
        cmd_o.emit = 1'b1;
        if (sts_i.base_gt_pc) begin
          cmd_o.set_done = 1'b1;
          cmd_o.kind     = K_DONE;
        end else begin
          cmd_o.kind = K_ACK;
        end
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (sts_i.pend_cur) begin
          cmd_o.scan_read = 1'b1;
          state_d         = ST_UPD;
        end else if (sts_i.scan_last) begin
          state_d = ST_FLUSH;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      ST_UPD: begin
        cmd_o.scan_upd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_FLUSH;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = ST_SCAN;
        end
      end
      ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_rem_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.rem_done |-> state_q == ST_REM)
    else $error("slot index ready outside of wait state");

  a_capture_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == ST_DISPATCH)
    else $error("request captured without dispatch");

endmodule

// File: design/selective_repeat_sender_window.sv
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Sender window of a selective-repeat transfer. A request is taken when start
// is high and busy is low; busy stays high until its last result has been
// registered. Results appear on result_valid_o for one cycle each and cannot
// be stalled; last_of_run_o marks the final result of a request. A rejected
// send or ack is answered from dispatch; otherwise a send or ack first waits
// for the bit-serial slot-index remainder unit; an ack that slides the base
// then walks slots until a pending slot, the window end or the next unsent
// sequence stops the slide; a tick walks every slot in the window and reads
// each outstanding slot from the slot store. Restart is handled at dispatch
// and gives no result.
// Configuration writes are always ready and must be issued while busy is low.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window #(
  parameter int unsigned MaxWindow = srsw_pkg::MaxWindowDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [srsw_pkg::OpW-1:0]      operation_i,
  input  logic [srsw_pkg::SeqW-1:0]     ack_number_i,
  input  logic                          ack_good_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [srsw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [srsw_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                          result_valid_o,
  output logic [srsw_pkg::KindW-1:0]    result_kind_o,
  output logic [srsw_pkg::SeqW-1:0]     sequence_res_o,
  output logic                          final_packet_o,
  output logic [srsw_pkg::SeqW-1:0]     window_low_o,
  output logic                          last_of_run_o
);

  import srsw_pkg::*;

  srsw_cmd_t cmd;
  srsw_sts_t sts;

  assign cfg_ready_o = 1'b1;

  srsw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  srsw_datapath #(
    .MaxWindow(MaxWindow)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .operation_i    (operation_i),
    .ack_number_i   (ack_number_i),
    .ack_good_i     (ack_good_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .result_kind_o  (result_kind_o),
    .sequence_res_o (sequence_res_o),
    .final_packet_o (final_packet_o),
    .window_low_o   (window_low_o),
    .last_of_run_o  (last_of_run_o)
  );

  a_partial_run_is_resend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_of_run_o |-> result_kind_o == K_RESEND && busy)
    else $error("non-final result outside a timeout scan");

endmodule
